// ===== rtl/epool_pkg.sv =====
package epool_pkg;

  // fixed field widths of the stream items
  localparam int IDX_W    = 9;
  localparam int STATUS_W = 2;
  localparam int TOTAL_W  = 10;
  localparam int S_DATA_W = 16;
  localparam int S_USER_W = 1;
  localparam int M_DATA_W = 24;

  // command codes carried in tuser
  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_EVICTED  = 2'd1,
    ST_INACTIVE = 2'd2
  } epool_status_e;

  // free stack update for one item
  typedef struct packed {
    logic pop;
    logic push;
  } epool_stk_op_t;

  // age list update for one item
  typedef struct packed {
    logic link_new;
    logic evict;
    logic unlink;
    logic list_empty;
  } epool_age_op_t;

endpackage

// ===== rtl/epool_stack.sv =====
module epool_stack #(
  parameter int ENTRIES = 512
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         rd_en_i,
  input  logic [$clog2(ENTRIES)-1:0]   rd_idx_i,
  input  epool_pkg::epool_stk_op_t     op_i,
  input  logic [$clog2(ENTRIES)-1:0]   push_idx_i,
  output logic [$clog2(ENTRIES)-1:0]   top_o,
  output logic [$clog2(ENTRIES+1)-1:0] total_o,
  output logic                         active_o
);
  import epool_pkg::*;

  localparam int IW = $clog2(ENTRIES);
  localparam int CW = $clog2(ENTRIES+1);

  logic [IW-1:0] link_mem [ENTRIES];
  logic          act_mem  [ENTRIES];

  logic [IW-1:0] top_q, top_d;
  logic [CW-1:0] total_q, total_d;
  // entries at or above hw_q were never popped: their link is index plus one
  logic [CW-1:0] hw_q, hw_d;

  logic [IW-1:0] link_rd_q;
  logic          virgin_q;
  logic          act_rd_q;
  logic          act_valid_q;
  logic [IW-1:0] next_top;

  assign next_top = virgin_q ? top_q + IW'(1) : link_rd_q;

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      link_rd_q   <= link_mem[top_q];
      virgin_q    <= (CW'(top_q) >= hw_q);
      act_rd_q    <= act_mem[rd_idx_i];
      act_valid_q <= (CW'(rd_idx_i) < hw_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (op_i.push) begin
      link_mem[push_idx_i] <= top_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (op_i.pop) begin
      act_mem[top_q] <= 1'b1;
    end else if (op_i.push) begin
      act_mem[push_idx_i] <= 1'b0;
    end
  end

  always_comb begin
    top_d   = top_q;
    total_d = total_q;
    hw_d    = hw_q;
    if (op_i.pop) begin
      top_d   = next_top;
      total_d = total_q - CW'(1);
      if (virgin_q) begin
        hw_d = CW'(top_q) + CW'(1);
      end
    end else if (op_i.push) begin
      top_d   = push_idx_i;
      total_d = total_q + CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      top_q   <= '0;
      total_q <= CW'(ENTRIES);
      hw_q    <= '0;
    end else begin
      top_q   <= top_d;
      total_q <= total_d;
      hw_q    <= hw_d;
    end
  end

  assign top_o    = top_q;
  assign total_o  = total_q;
  assign active_o = act_rd_q & act_valid_q;

  a_total_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (total_q <= CW'(ENTRIES)) && (hw_q <= CW'(ENTRIES)))
    else $error("free count or fill mark beyond pool size");

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    op_i.pop |-> (total_q != '0) && !op_i.push)
    else $error("pop from empty free stack");

  a_push_notfull: assert property (@(posedge clk_i) disable iff (!rst_ni)
    op_i.push |-> (total_q != CW'(ENTRIES)))
    else $error("push onto full free stack");

endmodule

// ===== rtl/epool_age.sv =====
module epool_age #(
  parameter int ENTRIES = 512
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       rd_en_i,
  input  logic                       rd_oldest_i,
  input  logic [$clog2(ENTRIES)-1:0] rd_idx_i,
  input  epool_pkg::epool_age_op_t   op_i,
  input  logic [$clog2(ENTRIES)-1:0] entry_i,
  output logic [$clog2(ENTRIES)-1:0] oldest_o
);
  import epool_pkg::*;

  localparam int IW = $clog2(ENTRIES);

  logic [IW-1:0] older_mem [ENTRIES];
  logic [IW-1:0] newer_mem [ENTRIES];

  logic [IW-1:0] oldest_q, oldest_d;
  logic [IW-1:0] newest_q, newest_d;
  logic [IW-1:0] older_rd_q, newer_rd_q;

  logic          older_we, newer_we;
  logic [IW-1:0] older_wa, older_wd, newer_wa, newer_wd;
  logic          is_oldest, is_newest;

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      older_rd_q <= older_mem[rd_idx_i];
      newer_rd_q <= newer_mem[rd_oldest_i ? oldest_q : rd_idx_i];
    end
  end

  assign is_oldest = (entry_i == oldest_q);
  assign is_newest = (entry_i == newest_q);

  always_comb begin
    oldest_d = oldest_q;
    newest_d = newest_q;
    older_we = 1'b0;
    older_wa = entry_i;
    older_wd = newest_q;
    newer_we = 1'b0;
    newer_wa = newest_q;
    newer_wd = entry_i;
    if (op_i.link_new) begin
      if (op_i.list_empty) begin
        oldest_d = entry_i;
      end else begin
        older_we = 1'b1;
        newer_we = 1'b1;
      end
      newest_d = entry_i;
    end else if (op_i.evict) begin
      // oldest leaves the tail and rejoins as the newest
      oldest_d = newer_rd_q;
      older_we = 1'b1;
      older_wa = oldest_q;
      newer_we = 1'b1;
      newer_wd = oldest_q;
      newest_d = oldest_q;
    end else if (op_i.unlink) begin
      if (is_oldest && is_newest) begin
        oldest_d = '0;
        newest_d = '0;
      end else begin
        if (is_oldest) begin
          oldest_d = newer_rd_q;
        end else begin
          newer_we = 1'b1;
          newer_wa = older_rd_q;
          newer_wd = newer_rd_q;
        end
        if (is_newest) begin
          newest_d = older_rd_q;
        end else begin
          older_we = 1'b1;
          older_wa = newer_rd_q;
          older_wd = older_rd_q;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (older_we) begin
      older_mem[older_wa] <= older_wd;
    end
    if (newer_we) begin
      newer_mem[newer_wa] <= newer_wd;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      oldest_q <= '0;
      newest_q <= '0;
    end else begin
      oldest_q <= oldest_d;
      newest_q <= newest_d;
    end
  end

  assign oldest_o = oldest_q;

  a_one_op: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({op_i.link_new, op_i.evict, op_i.unlink}))
    else $error("more than one age list update in a cycle");

endmodule

// ===== rtl/entry_pool_with_oldest_eviction.sv =====
// Pool allocator for ENTRIES entries with oldest-first eviction. Each input item is a
// command: allocate (tuser 0) pops the free stack, which starts as 0, 1, 2 and so on, and
// makes that entry the newest; when nothing is free the oldest active entry is handed
// out again with status evicted. Free (tuser 1) unlinks the named entry and pushes it on
// the free stack; naming an entry that is not active, or one beyond the pool, gives
// status inactive and changes nothing. Every command gives exactly one result item with
// the granted or named entry, the status and the active count after the command. An
// item is handled in two steps: acceptance reads the link and flag memories into their
// read registers, then, once the output register is free or being drained, the state is
// updated and the output register loaded; no new item is taken before that update. No
// clearing pass is needed after reset: a fill mark tracks the entries never handed out.
module entry_pool_with_oldest_eviction #(
  parameter int ENTRIES = 512
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [15:0] s_axis_tdata_i,   // [8:0] entry_index, rest zero
  input  logic [0:0]  s_axis_tuser_i,   // [0] command
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [23:0] m_axis_tdata_o    // [8:0] granted_index, [10:9] status,
                                        // [20:11] active_total, rest zero
);
  import epool_pkg::*;

  localparam int IW = $clog2(ENTRIES);
  localparam int CW = $clog2(ENTRIES+1);

  // input register, holds the command while its reads complete
  logic             busy_q;
  logic             cmd_q;
  logic [IDX_W-1:0] idx_q;

  logic accept;
  logic fire;

  // output register
  logic                out_valid_q;
  logic [M_DATA_W-1:0] out_data_q;

  logic [IW-1:0] idx_in_w;
  logic [IW-1:0] idx_w;
  logic [IW-1:0] top;
  logic [IW-1:0] oldest;
  logic [CW-1:0] total;
  logic          active_rd;

  logic          is_alloc;
  logic          full;
  logic          in_range;
  logic          free_ok;
  logic [IW-1:0] alloc_entry;
  logic [CW-1:0] act_now;
  logic [CW-1:0] act_next;

  logic [IDX_W-1:0]   granted;
  epool_status_e      status;
  logic [TOTAL_W-1:0] act_out;

  epool_stk_op_t stk_op;
  epool_age_op_t age_op;

  assign s_axis_tready_o = !busy_q;
  assign accept          = s_axis_tvalid_i && !busy_q;
  // the update runs once the output register is free or being emptied
  assign fire            = busy_q && (!out_valid_q || m_axis_tready_i);

  assign idx_in_w = IW'(s_axis_tdata_i[IDX_W-1:0]);
  assign idx_w    = IW'(idx_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else if (accept) begin
      busy_q <= 1'b1;
    end else if (fire) begin
      busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q <= s_axis_tuser_i[0];
      idx_q <= s_axis_tdata_i[IDX_W-1:0];
    end
  end

  // decision logic for the held command
  assign is_alloc    = (cmd_q == CMD_ALLOC);
  assign full        = (total == '0);
  assign in_range    = (32'(idx_q) < ENTRIES);
  assign free_ok     = !is_alloc && in_range && active_rd;
  // on a full pool the victim is pushed and popped again at once: the stack stays put
  assign alloc_entry = full ? oldest : top;

  always_comb begin
    stk_op.pop  = fire && is_alloc && !full;
    stk_op.push = fire && free_ok;

    age_op.link_new   = fire && is_alloc && !full;
    age_op.evict      = fire && is_alloc && full;
    age_op.unlink     = fire && free_ok;
    age_op.list_empty = (total == CW'(ENTRIES));
  end

  assign act_now = CW'(ENTRIES) - total;

  always_comb begin
    act_next = act_now;
    if (is_alloc && !full) begin
      act_next = act_now + CW'(1);
    end else if (free_ok) begin
      act_next = act_now - CW'(1);
    end
  end

  always_comb begin
    if (is_alloc) begin
      granted = IDX_W'(alloc_entry);
      status  = full ? ST_EVICTED : ST_OK;
    end else begin
      granted = idx_q;
      status  = free_ok ? ST_OK : ST_INACTIVE;
    end
  end

  assign act_out = TOTAL_W'(act_next);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_data_q <= {3'b000, act_out, status, granted};
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

  // free stack, fill mark and active flags
  epool_stack #(
    .ENTRIES (ENTRIES)
  ) u_stack (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_en_i    (accept),
    .rd_idx_i   (idx_in_w),
    .op_i       (stk_op),
    .push_idx_i (idx_w),
    .top_o      (top),
    .total_o    (total),
    .active_o   (active_rd)
  );

  // doubly linked age list
  epool_age #(
    .ENTRIES (ENTRIES)
  ) u_age (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rd_en_i     (accept),
    .rd_oldest_i (s_axis_tuser_i[0] == CMD_ALLOC),
    .rd_idx_i    (idx_in_w),
    .op_i        (age_op),
    .entry_i     (is_alloc ? top : idx_w),
    .oldest_o    (oldest)
  );

endmodule
